[hw/rtl/ognb_pkg.sv]
// Package with shared constants, codes and types of the nearest-obstacle block.
`timescale 1ns / 1ps
package ognb_pkg;

  localparam int GRID_W_DEF     = 64;
  localparam int GRID_H_DEF     = 64;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int DATA_W = 16;
  localparam int FX_W   = 32;
  localparam int CX_W   = 20;
  localparam int IDX_W  = 22;
  localparam int CFG_AW = 3;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_AREA_W = 3'd0,
    CFG_AREA_H = 3'd1,
    CFG_CPU_X  = 3'd2,
    CFG_CPU_Y  = 3'd3,
    CFG_UPC_X  = 3'd4,
    CFG_UPC_Y  = 3'd5,
    CFG_RSV6   = 3'd6,
    CFG_RSV7   = 3'd7
  } cfg_idx_t;

  // Control from the sequencer to the distance pipeline.
  typedef struct packed {
    logic push;
    logic clr;
  } pipe_ctl_t;

endpackage

[hw/rtl/ognb_if.sv]
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface ognb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] max_dist;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic        cell_value;

  modport source (output valid, func, pos_x, pos_y, max_dist, cell_x, cell_y, cell_value,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, max_dist, cell_x, cell_y, cell_value,
                output ready);
endinterface

interface ognb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

[hw/rtl/occupancy_grid_nearest_obstacle_core.sv]
// Nearest-obstacle distance on a one-bit occupancy grid, top level and sequencer.
// The grid lives in a RAM of GRID_H rows of GRID_W bits; one item is handled at a time.
// A cell write reads the row, writes it back with the one bit changed and then gives its
// result. A clear, and the pass that runs after reset before any request is taken, sweep
// all GRID_H rows. A query reads each window row that lies in the grid, scans it column by
// column into the distance pipeline and skips rows outside the grid; it then waits for the
// pipeline to drain, takes the square root and gives the result. With MAX_RADIUS 8 a full
// window is 17 by 17 cells. The column scan, one cell per cycle, takes most of a query's
// time. A finished result sits in an output register, so the next request is taken
// while it waits.
`timescale 1ns / 1ps
module occupancy_grid_nearest_obstacle_core #(
  parameter int GRID_W     = ognb_pkg::GRID_W_DEF,
  parameter int GRID_H     = ognb_pkg::GRID_H_DEF,
  parameter int MAX_RADIUS = ognb_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ognb_in_if.sink                     in_req,
  ognb_out_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [ognb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [15:0]                 cfg_wdata
);

  localparam int IDX_W = ognb_pkg::IDX_W;
  localparam int FX_W  = ognb_pkg::FX_W;
  localparam int CX_W  = ognb_pkg::CX_W;
  localparam int AW    = $clog2(GRID_H);
  localparam int IW    = $clog2(GRID_W);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int MW    = $clog2((MAX_RADIUS + 1) * 4096);
  localparam int DXW   = MW + 4;
  localparam int SQ    = 2 * DXW;
  localparam int VW    = SQ + 1 - 8;
  localparam int SQW   = (VW + 1) / 2;
  localparam int DW    = FX_W + 2;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_WRRD  = 13'b0000000000100,
    S_WR    = 13'b0000000001000,
    S_Q0    = 13'b0000000010000,
    S_Q1    = 13'b0000000100000,
    S_ROW   = 13'b0000001000000,
    S_DY    = 13'b0000010000000,
    S_DY2   = 13'b0000100000000,
    S_COL   = 13'b0001000000000,
    S_DRAIN = 13'b0010000000000,
    S_SQRT  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] area_w_r, area_h_r, cpu_x_r, cpu_y_r, upc_x_r, upc_y_r;

  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             clr_rsp_r, clr_rsp_nxt;
  logic [15:0]      px_r, px_nxt, py_r, py_nxt, lim_r, lim_nxt;
  logic [5:0]       wx_r, wx_nxt, wy_r, wy_nxt;
  logic             wv_r, wv_nxt;
  logic [FX_W-1:0]  fx_r, fx_nxt, fy_r, fy_nxt;
  logic [CX_W-1:0]  rxraw_r, rxraw_nxt, ryraw_r, ryraw_nxt;
  logic signed [IDX_W-1:0] i_r, i_nxt, istart_r, istart_nxt, iend_r, iend_nxt;
  logic signed [IDX_W-1:0] j_r, j_nxt, jend_r, jend_nxt;
  logic [MW-1:0]    my_r, my_nxt;
  logic [DXW-1:0]   dy_r, dy_nxt;
  logic [SQ-1:0]    dysq_r, dysq_nxt;
  logic [15:0]      res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_dist_r, out_dist_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [GRID_W-1:0] ram_wdata, ram_rdata;

  ognb_pkg::pipe_ctl_t pipe_ctl;
  logic             pipe_busy, pipe_found;
  logic [VW-1:0]    pipe_min;
  logic             sq_start, sq_busy;
  logic [SQW-1:0]   sq_root;

  logic [31:0]      lim_x_prod, lim_y_prod;
  logic [RW-1:0]    rx, ry;
  logic [CX_W-1:0]  cx, cy;
  logic             i_in_grid, j_in_grid;
  logic signed [DW-1:0] ydiff;
  logic [DW-1:0]    ymag;
  logic [MW+15:0]   yprod;
  logic [31:0]      best, edge_w, edge_h;
  logic             out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_w_r <= 16'd1024;
      area_h_r <= 16'd1024;
      cpu_x_r  <= 16'd256;
      cpu_y_r  <= 16'd256;
      upc_x_r  <= 16'd256;
      upc_y_r  <= 16'd256;
    end else if (cfg_we) begin
      unique case (ognb_pkg::cfg_idx_t'(cfg_addr))
        ognb_pkg::CFG_AREA_W: area_w_r <= cfg_wdata;
        ognb_pkg::CFG_AREA_H: area_h_r <= cfg_wdata;
        ognb_pkg::CFG_CPU_X:  cpu_x_r  <= cfg_wdata;
        ognb_pkg::CFG_CPU_Y:  cpu_y_r  <= cfg_wdata;
        ognb_pkg::CFG_UPC_X:  upc_x_r  <= cfg_wdata;
        ognb_pkg::CFG_UPC_Y:  upc_y_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cx = fx_r[FX_W-1:12];
    cy = fy_r[FX_W-1:12];
    rx = (rxraw_r > CX_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : rxraw_r[RW-1:0];
    ry = (ryraw_r > CX_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : ryraw_r[RW-1:0];
    lim_x_prod = 32'(lim_r) * 32'(cpu_x_r);
    lim_y_prod = 32'(lim_r) * 32'(cpu_y_r);
    i_in_grid = !i_r[IDX_W-1] && (i_r < $signed(IDX_W'(GRID_W)));
    j_in_grid = !j_r[IDX_W-1] && (j_r < $signed(IDX_W'(GRID_H)));
    ydiff = $signed({2'b00, fy_r}) - ($signed(DW'(j_r)) <<< 12);
    ymag  = ydiff[DW-1] ? DW'(-ydiff) : DW'(ydiff);
    yprod = (MW+16)'(my_r) * (MW+16)'(upc_y_r);
    edge_w = (area_w_r > px_r) ? 32'(area_w_r - px_r) : 32'd0;
    edge_h = (area_h_r > py_r) ? 32'(area_h_r - py_r) : 32'd0;
    best = 32'(lim_r);
    if (pipe_found && (32'(sq_root) < best)) best = 32'(sq_root);
    if (32'(px_r) < best) best = 32'(px_r);
    if (32'(py_r) < best) best = 32'(py_r);
    if (edge_w < best) best = edge_w;
    if (edge_h < best) best = edge_h;
  end

  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_rsp_nxt = clr_rsp_r;
    px_nxt = px_r;  py_nxt = py_r;  lim_nxt = lim_r;
    wx_nxt = wx_r;  wy_nxt = wy_r;  wv_nxt = wv_r;
    fx_nxt = fx_r;  fy_nxt = fy_r;
    rxraw_nxt = rxraw_r;  ryraw_nxt = ryraw_r;
    i_nxt = i_r;  istart_nxt = istart_r;  iend_nxt = iend_r;
    j_nxt = j_r;  jend_nxt = jend_r;
    my_nxt = my_r;  dy_nxt = dy_r;  dysq_nxt = dysq_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_dist_nxt  = out_dist_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr  = clr_cnt_r;
    ram_wdata = '0;
    pipe_ctl  = '0;
    sq_start  = 1'b0;
    in_req.ready = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(GRID_H - 1)) begin
          clr_cnt_nxt = '0;
          res_nxt = '0;
          state_nxt = clr_rsp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        in_req.ready = 1'b1;
        px_nxt = in_req.pos_x;
        py_nxt = in_req.pos_y;
        lim_nxt = in_req.max_dist;
        wx_nxt = in_req.cell_x;
        wy_nxt = in_req.cell_y;
        wv_nxt = in_req.cell_value;
        res_nxt = '0;
        if (in_req.valid) begin
          unique case (ognb_pkg::func_t'(in_req.func))
            ognb_pkg::FUNC_WRITE: begin
              if ((32'(in_req.cell_x) < 32'(GRID_W)) && (32'(in_req.cell_y) < 32'(GRID_H))) begin
                state_nxt = S_WRRD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            ognb_pkg::FUNC_QUERY: state_nxt = S_Q0;
            ognb_pkg::FUNC_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_rsp_nxt = 1'b1;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WRRD: begin
        ram_re = 1'b1;
        ram_addr = AW'(wy_r);
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_addr = AW'(wy_r);
        ram_wdata = ram_rdata;
        ram_wdata[IW'(wx_r)] = wv_r;
        state_nxt = S_DONE;
      end
      S_Q0: begin
        fx_nxt = 32'(px_r) * 32'(cpu_x_r);
        fy_nxt = 32'(py_r) * 32'(cpu_y_r);
        rxraw_nxt = lim_x_prod[31:12];
        ryraw_nxt = lim_y_prod[31:12];
        state_nxt = S_Q1;
      end
      S_Q1: begin
        istart_nxt = $signed({2'b00, cx}) - $signed(IDX_W'(rx));
        iend_nxt   = $signed({2'b00, cx}) + $signed(IDX_W'(rx));
        j_nxt      = $signed({2'b00, cy}) - $signed(IDX_W'(ry));
        jend_nxt   = $signed({2'b00, cy}) + $signed(IDX_W'(ry));
        pipe_ctl.clr = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        if (j_in_grid) begin
          ram_re = 1'b1;
          ram_addr = j_r[AW-1:0];
          my_nxt = ymag[MW-1:0];
          state_nxt = S_DY;
        end else if (j_r == jend_r) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DY: begin
        dy_nxt = yprod[MW+15:12];
        state_nxt = S_DY2;
      end
      S_DY2: begin
        dysq_nxt = SQ'(dy_r) * SQ'(dy_r);
        i_nxt = istart_r;
        state_nxt = S_COL;
      end
      S_COL: begin
        pipe_ctl.push = i_in_grid && ram_rdata[i_r[IW-1:0]];
        i_nxt = i_r + 1'b1;
        if (i_r == iend_r) begin
          if (j_r == jend_r) begin
            state_nxt = S_DRAIN;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_ROW;
          end
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          sq_start = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sq_busy) begin
          res_nxt = best[15:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt = res_r;
          clr_rsp_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r <= px_nxt;  py_r <= py_nxt;  lim_r <= lim_nxt;
    wx_r <= wx_nxt;  wy_r <= wy_nxt;  wv_r <= wv_nxt;
    fx_r <= fx_nxt;  fy_r <= fy_nxt;
    rxraw_r <= rxraw_nxt;  ryraw_r <= ryraw_nxt;
    i_r <= i_nxt;  istart_r <= istart_nxt;  iend_r <= iend_nxt;
    j_r <= j_nxt;  jend_r <= jend_nxt;
    my_r <= my_nxt;  dy_r <= dy_nxt;  dysq_r <= dysq_nxt;
    res_r <= res_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.distance = out_dist_r;

  ognb_ram #(.WIDTH(GRID_W), .DEPTH(GRID_H)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ognb_dist_pipe #(.MAX_RADIUS(MAX_RADIUS)) u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pipe_ctl),
    .col   (i_r),
    .fx    (fx_r),
    .upc   (upc_x_r),
    .dysq  (dysq_r),
    .busy  (pipe_busy),
    .found (pipe_found),
    .min_v (pipe_min)
  );

  ognb_sqrt #(.VW(VW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (pipe_min),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // No request may be taken while the grid is being swept clear.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_req.ready)
    else $error("request taken during clear sweep");

  // The grid is written only by the clear sweep or a cell write.
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_CLEAR) || (state_r == S_WR)))
    else $error("grid written outside clear or cell write");

  // The root starts only once every scanned cell has left the pipeline.
  a_sqrt_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !pipe_busy)
    else $error("square root started with cells in flight");

  // A result leaves the done state only into a free output register.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not presented after done");

endmodule

[hw/rtl/ognb_ram.sv]
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module ognb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/ognb_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ognb_sqrt #(
  parameter int VW = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VW-1:0]         radicand,
  output logic                  busy,
  output logic [(VW+1)/2-1:0]   root
);

  localparam int SQW  = (VW + 1) / 2;
  localparam int REMW = SQW + 4;
  localparam int CNTW = $clog2(SQW + 1);

  logic            busy_r, busy_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [2*SQW-1:0] rad_r, rad_nxt;
  logic [REMW-1:0] rem_r, rem_nxt;
  logic [SQW-1:0]  root_r, root_nxt;
  logic [REMW-1:0] cat;
  logic [REMW-1:0] trial;

  always_comb begin
    cat      = {rem_r[REMW-3:0], rad_r[2*SQW-1 -: 2]};
    trial    = REMW'({root_r, 2'b01});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = (2*SQW)'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[2*SQW-3:0], 2'b00};
      if (cat >= trial) begin
        rem_nxt  = cat - trial;
        root_nxt = {root_r[SQW-2:0], 1'b1};
      end else begin
        rem_nxt  = cat;
        root_nxt = {root_r[SQW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(SQW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[hw/rtl/ognb_dist_pipe.sv]
// Four-stage pipeline that turns scanned cells into squared distances and keeps the minimum.
`timescale 1ns / 1ps
module ognb_dist_pipe #(
  parameter int MAX_RADIUS = ognb_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ognb_pkg::pipe_ctl_t                 ctl,
  input  logic signed [ognb_pkg::IDX_W-1:0]   col,
  input  logic [ognb_pkg::FX_W-1:0]           fx,
  input  logic [15:0]                         upc,
  input  logic [2*($clog2((MAX_RADIUS+1)*4096)+4)-1:0] dysq,
  output logic                                busy,
  output logic                                found,
  output logic [2*($clog2((MAX_RADIUS+1)*4096)+4)-8:0] min_v
);

  localparam int MW  = $clog2((MAX_RADIUS + 1) * 4096);
  localparam int DXW = MW + 4;
  localparam int SQ  = 2 * DXW;
  localparam int VW  = SQ + 1 - 8;
  localparam int DW  = ognb_pkg::FX_W + 2;

  logic                 v1_r, v2_r, v3_r;
  logic [MW-1:0]        mx_r;
  logic [DXW-1:0]       dx_r;
  logic [SQ-1:0]        dxsq_r;
  logic [SQ-1:0]        dy1_r, dy2_r, dy3_r;
  logic                 found_r, found_nxt;
  logic [VW-1:0]        min_r, min_nxt;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [MW+15:0]       prod;
  logic [SQ:0]          sum;

  always_comb begin
    // Only columns inside the window reach here, so the magnitude fits in MW bits.
    diff = $signed({2'b00, fx}) - ($signed(DW'(col)) <<< 12);
    mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    prod = MW'(mx_r) * (MW+16)'(upc);
    sum  = (SQ+1)'(dxsq_r) + (SQ+1)'(dy3_r);
    found_nxt = found_r;
    min_nxt   = min_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (v3_r) begin
      if (!found_r || (sum[SQ:8] < min_r)) begin
        min_nxt = sum[SQ:8];
      end
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r    <= ctl.push;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      found_r <= found_nxt;
    end
    mx_r   <= mag[MW-1:0];
    dy1_r  <= dysq;
    dx_r   <= prod[MW+15:12];
    dy2_r  <= dy1_r;
    dxsq_r <= SQ'(dx_r) * SQ'(dx_r);
    dy3_r  <= dy2_r;
    min_r  <= min_nxt;
  end

  assign busy  = v1_r | v2_r | v3_r;
  assign found = found_r;
  assign min_v = min_r;

endmodule

[dv/tb_occupancy_grid_nearest_obstacle_core.sv]
// Self-checking testbench for the occupancy-grid nearest-obstacle core.
`timescale 1ns / 1ps
module tb_occupancy_grid_nearest_obstacle_core;

  localparam int GW = ognb_pkg::GRID_W_DEF;
  localparam int GH = ognb_pkg::GRID_H_DEF;
  localparam int RMAX = ognb_pkg::MAX_RADIUS_DEF;

  typedef struct {
    ognb_pkg::func_t func;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] max_dist;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        cell_value;
    bit          fixed;
    logic [15:0] exp_dist;
  } grid_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ognb_pkg::CFG_AW-1:0] cfg_addr;
  logic [15:0] cfg_wdata;

  ognb_in_if  in_req ();
  ognb_out_if out_rsp ();

  occupancy_grid_nearest_obstacle_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the grid and registers.
  bit          occ [GH][GW];
  logic [15:0] area_w, area_h, cpu_x, cpu_y, upc_x, upc_y;

  logic [15:0] dist_fifo [$];
  int          mismatches;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_len;
  bit          hold_go;
  int          hold_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cell_offset(longint f, longint k, logic [15:0] scale);
    longint dd;
    longint unsigned m;
    dd = f - k * 4096;
    m = (dd < 0) ? -dd : dd;
    return (m * scale) >> 12;
  endfunction

  function automatic longint window_radius(logic [15:0] lim, logic [15:0] cpu);
    longint unsigned r;
    r = (longint'(lim) * longint'(cpu)) >> 12;
    if (r > RMAX) r = RMAX;
    return r;
  endfunction

  function automatic logic [15:0] nearest_dist(logic [15:0] px, logic [15:0] py,
                                               logic [15:0] lim);
    longint fx, fy, cx, cy, rx, ry, i, j;
    longint unsigned best, dx, dy, dd, e;
    fx = longint'(px) * longint'(cpu_x);
    fy = longint'(py) * longint'(cpu_y);
    cx = fx >>> 12;
    cy = fy >>> 12;
    rx = window_radius(lim, cpu_x);
    ry = window_radius(lim, cpu_y);
    best = lim;
    for (i = cx - rx; i <= cx + rx; i++) begin
      if (i < 0 || i >= GW) continue;
      for (j = cy - ry; j <= cy + ry; j++) begin
        if (j < 0 || j >= GH) continue;
        if (!occ[j][i]) continue;
        dx = cell_offset(fx, i, upc_x);
        dy = cell_offset(fy, j, upc_y);
        dd = isqrt((dx * dx + dy * dy) >> 8);
        if (dd < best) best = dd;
      end
    end
    if (px < best) best = px;
    if (py < best) best = py;
    e = (area_w > px) ? area_w - px : 0;
    if (e < best) best = e;
    e = (area_h > py) ? area_h - py : 0;
    if (e < best) best = e;
    return best[15:0];
  endfunction

  // Applies an accepted request to the shadow grid and returns its answer.
  function automatic logic [15:0] apply_request(grid_req_t r);
    logic [15:0] res;
    res = '0;
    case (r.func)
      ognb_pkg::FUNC_WRITE: occ[r.cell_y][r.cell_x] = r.cell_value;
      ognb_pkg::FUNC_QUERY: res = nearest_dist(r.pos_x, r.pos_y, r.max_dist);
      ognb_pkg::FUNC_CLEAR: occ = '{default: '0};
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_req(grid_req_t r);
    logic [15:0] pred;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.func       <= r.func;
    in_req.pos_x      <= r.pos_x;
    in_req.pos_y      <= r.pos_y;
    in_req.max_dist   <= r.max_dist;
    in_req.cell_x     <= r.cell_x;
    in_req.cell_y     <= r.cell_y;
    in_req.cell_value <= r.cell_value;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pred = apply_request(r);
    dist_fifo.push_back(r.fixed ? r.exp_dist : pred);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    in_req.valid <= 1'b0;
    while (dist_fifo.size() != 0) @(posedge clk);
    // A finished result leaves the block idle; the repeat below only adds margin.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(ognb_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ognb_pkg::CFG_AREA_W: area_w = val;
      ognb_pkg::CFG_AREA_H: area_h = val;
      ognb_pkg::CFG_CPU_X:  cpu_x = val;
      ognb_pkg::CFG_CPU_Y:  cpu_y = val;
      ognb_pkg::CFG_UPC_X:  upc_x = val;
      ognb_pkg::CFG_UPC_Y:  upc_y = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [15:0] aw, logic [15:0] ah, logic [15:0] cx,
                                logic [15:0] cy, logic [15:0] ux, logic [15:0] uy);
    write_reg(ognb_pkg::CFG_AREA_W, aw);
    write_reg(ognb_pkg::CFG_AREA_H, ah);
    write_reg(ognb_pkg::CFG_CPU_X, cx);
    write_reg(ognb_pkg::CFG_CPU_Y, cy);
    write_reg(ognb_pkg::CFG_UPC_X, ux);
    write_reg(ognb_pkg::CFG_UPC_Y, uy);
  endtask

  function automatic grid_req_t random_req();
    grid_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.fixed      = 1'b0;
    r.exp_dist   = '0;
    r.cell_x     = 6'($urandom_range(63));
    r.cell_y     = 6'($urandom_range(63));
    r.cell_value = ($urandom_range(3) != 0);
    // Positions mostly fall inside the mapped area so windows hit the grid.
    if ($urandom_range(9) == 0) begin
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
    end else begin
      r.pos_x = 16'($urandom_range(1100));
      r.pos_y = 16'($urandom_range(1100));
    end
    r.max_dist = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(200));
    if (pick < 45)      r.func = ognb_pkg::FUNC_WRITE;
    else if (pick < 93) r.func = ognb_pkg::FUNC_QUERY;
    else if (pick < 96) r.func = ognb_pkg::FUNC_CLEAR;
    else                r.func = ognb_pkg::FUNC_NONE;
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = hold_len;
      hold_go = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (dist_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result distance=%0d", out_rsp.distance);
      end else begin
        logic [15:0] want;
        want = dist_fifo.pop_front();
        if (out_rsp.distance !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, out_rsp.distance);
        end
      end
    end
  end

  grid_req_t directed [] = '{
    // After reset the grid is empty: answers are limit or edge distances.
    '{ognb_pkg::FUNC_QUERY, 16'd512, 16'd512, 16'd0, 6'd0, 6'd0, 1'b0, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd512, 16'd512, 16'hFFFF, 6'd0, 6'd0, 1'b0, 1'b1, 16'd512},
    '{ognb_pkg::FUNC_QUERY, 16'd0, 16'd300, 16'd100, 6'd0, 6'd0, 1'b0, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 1'b0, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd1000, 16'd500, 16'hFFFF, 6'd0, 6'd0, 1'b0, 1'b1, 16'd24},
    '{ognb_pkg::FUNC_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 1'b1, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'd0, 6'd63, 6'd63, 1'b1, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'd0, 6'd32, 6'd32, 1'b1, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd8, 16'd8, 16'd200, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd1016, 16'd1016, 16'hFFFF, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd530, 16'd525, 16'd300, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd520, 16'd540, 16'd40, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63, 1'b1, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd530, 16'd525, 16'd300, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'd0, 6'd32, 6'd32, 1'b0, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd530, 16'd525, 16'd300, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0},
    '{ognb_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63, 1'b1, 1'b1, 16'd0},
    '{ognb_pkg::FUNC_QUERY, 16'd1016, 16'd1016, 16'hFFFF, 6'd0, 6'd0, 1'b0, 1'b1, 16'd8}
  };

  initial begin
    int phase_idle [5] = '{0, 87, 0, 17, 0};
    int phase_stall [5] = '{0, 0, 87, 17, 0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = ognb_pkg::CFG_AREA_W;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.func = ognb_pkg::FUNC_WRITE;
    in_req.pos_x = '0;
    in_req.pos_y = '0;
    in_req.max_dist = '0;
    in_req.cell_x = '0;
    in_req.cell_y = '0;
    in_req.cell_value = 1'b0;
    out_rsp.ready = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_go = 1'b0;
    hold_left = 0;
    occ = '{default: '0};
    area_w = 16'd1024;
    area_h = 16'd1024;
    cpu_x = 16'd256;
    cpu_y = 16'd256;
    upc_x = 16'd256;
    upc_y = 16'd256;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) send_req(directed[k]);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all_regs(16'd1024, 16'd1024, 16'd256, 16'd256, 16'd256, 16'd256);
        1: write_all_regs(16'($urandom_range(400, 2000)), 16'($urandom_range(400, 2000)),
                          16'($urandom_range(64, 1024)), 16'($urandom_range(64, 1024)),
                          16'($urandom_range(64, 1024)), 16'($urandom_range(64, 1024)));
        2: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: write_all_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        default: begin
          write_all_regs(16'd800, 16'd1200, 16'd300, 16'd200, 16'd128, 16'd512);
          // Unused indexes must leave every register alone.
          write_reg(ognb_pkg::CFG_RSV6, 16'hFFFF);
          write_reg(ognb_pkg::CFG_RSV7, 16'h0000);
        end
      endcase
      send_idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) begin
        hold_len = 3000;
        hold_go = 1'b1;
      end
      repeat (160) send_req(random_req());
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && dist_fifo.size() == 0) begin
      $display("tb_occupancy_grid_nearest_obstacle_core passed");
    end else begin
      $display("tb_occupancy_grid_nearest_obstacle_core failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_occupancy_grid_nearest_obstacle_core failed");
    $finish;
  end

endmodule
